// ----- rtl/ffba_pkg.sv -----
package ffba_pkg;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_DEFRAG = 2'd2;

    localparam logic [2:0] STAT_ALLOC_OK  = 3'd0;
    localparam logic [2:0] STAT_NO_SPACE  = 3'd1;
    localparam logic [2:0] STAT_ERASE_OK  = 3'd2;
    localparam logic [2:0] STAT_ILLEGAL   = 3'd3;
    localparam logic [2:0] STAT_DEFRAG    = 3'd4;
    localparam logic [2:0] STAT_EXHAUSTED = 3'd5;

    localparam logic [7:0] MEM_SIZE_RESET = 8'd128;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] alloc_size;
        logic [9:0] erase_id;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] block_id;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_A_SCAN,
        S_A_FILL,
        S_E_SCAN,
        S_D_SCAN,
        S_D_ZERO
    } state_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic       alloc_chk;
        logic       erase_chk;
        logic       defrag_chk;
        logic       fill_id;
        logic       fill_zero;
        logic       emit;
        logic [2:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       exhausted;
        logic       size_bad;
        logic       id_zero;
        logic       rd_done;
        logic       pvalid;
        logic       fit;
        logic       found;
        logic       fill_done;
    } stat_t;

endpackage

// ----- rtl/ffba_ram.sv -----
module ffba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 128
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/ffba_ctrl.sv -----
module ffba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ffba_pkg::stat_t stat,
    output ffba_pkg::cmd_t  cmd,
    output logic            busy
);

    ffba_pkg::state_t state_reg;
    ffba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffba_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffba_pkg::S_CLEAR:
            begin
                if (stat.fill_done)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            ffba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ffba_pkg::S_DECIDE;
                end
            end
            ffba_pkg::S_DECIDE:
            begin
                case (stat.op)
                    ffba_pkg::OP_ALLOC:
                    begin
                        if (stat.exhausted || stat.size_bad)
                        begin
                            state_next = ffba_pkg::S_IDLE;
                        end
                        else
                        begin
                            state_next = ffba_pkg::S_A_SCAN;
                        end
                    end
                    ffba_pkg::OP_ERASE:
                    begin
                        if (stat.id_zero)
                        begin
                            state_next = ffba_pkg::S_IDLE;
                        end
                        else
                        begin
                            state_next = ffba_pkg::S_E_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ffba_pkg::S_D_SCAN;
                    end
                endcase
            end
            ffba_pkg::S_A_SCAN:
            begin
                if (stat.fit)
                begin
                    state_next = ffba_pkg::S_A_FILL;
                end
                else if (stat.rd_done && !stat.pvalid)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            ffba_pkg::S_A_FILL:
            begin
                if (stat.fill_done)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            ffba_pkg::S_E_SCAN:
            begin
                if (stat.rd_done && !stat.pvalid)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            ffba_pkg::S_D_SCAN:
            begin
                if (stat.rd_done && !stat.pvalid)
                begin
                    state_next = ffba_pkg::S_D_ZERO;
                end
            end
            ffba_pkg::S_D_ZERO:
            begin
                if (stat.fill_done)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.status = ffba_pkg::STAT_NO_SPACE;
        busy       = (state_reg != ffba_pkg::S_IDLE);
        case (state_reg)
            ffba_pkg::S_CLEAR:
            begin
                cmd.fill_zero = !stat.fill_done;
            end
            ffba_pkg::S_IDLE:
            begin
                cmd.load = start;
            end
            ffba_pkg::S_DECIDE:
            begin
                case (stat.op)
                    ffba_pkg::OP_ALLOC:
                    begin
                        if (stat.exhausted)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = ffba_pkg::STAT_EXHAUSTED;
                        end
                        else if (stat.size_bad)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = ffba_pkg::STAT_NO_SPACE;
                        end
                    end
                    ffba_pkg::OP_ERASE:
                    begin
                        if (stat.id_zero)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = ffba_pkg::STAT_ILLEGAL;
                        end
                    end
                    default:
                    begin
                        cmd.emit = 1'b0;
                    end
                endcase
            end
            ffba_pkg::S_A_SCAN:
            begin
                cmd.rd_en     = !stat.fit;
                cmd.alloc_chk = !stat.fit;
                if (!stat.fit && stat.rd_done && !stat.pvalid)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ffba_pkg::STAT_NO_SPACE;
                end
            end
            ffba_pkg::S_A_FILL:
            begin
                if (stat.fill_done)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ffba_pkg::STAT_ALLOC_OK;
                end
                else
                begin
                    cmd.fill_id = 1'b1;
                end
            end
            ffba_pkg::S_E_SCAN:
            begin
                cmd.rd_en     = 1'b1;
                cmd.erase_chk = 1'b1;
                if (stat.rd_done && !stat.pvalid)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = stat.found ? ffba_pkg::STAT_ERASE_OK
                                            : ffba_pkg::STAT_ILLEGAL;
                end
            end
            ffba_pkg::S_D_SCAN:
            begin
                cmd.rd_en      = 1'b1;
                cmd.defrag_chk = 1'b1;
            end
            ffba_pkg::S_D_ZERO:
            begin
                if (stat.fill_done)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ffba_pkg::STAT_DEFRAG;
                end
                else
                begin
                    cmd.fill_zero = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_decide_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffba_pkg::S_DECIDE) |-> $past(start && state_reg == ffba_pkg::S_IDLE))
        else $error("decide without an accepted transfer");

    a_emit_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == ffba_pkg::S_IDLE))
        else $error("result issued but controller not idle");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffba_pkg::S_IDLE && !start) |=> (state_reg == ffba_pkg::S_IDLE))
        else $error("controller left idle without a transfer");
`endif

endmodule

// ----- rtl/ffba_dp.sv -----
module ffba_dp #(
    parameter int MEM_CELLS = 128,
    parameter int MAX_IDS   = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ffba_pkg::req_t  req,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_wdata,
    input  ffba_pkg::cmd_t  cmd,
    output ffba_pkg::stat_t stat,
    output logic            done,
    output ffba_pkg::rsp_t  result
);

    localparam int CW    = $clog2(MEM_CELLS + 1);
    localparam int AW    = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
    localparam int ID_W  = $clog2(MAX_IDS);
    localparam int SW    = (CW > 8) ? CW : 8;
    localparam int CMP_W = (ID_W > 10) ? ID_W : 10;

    logic [7:0]      mem_size_reg;
    logic [ID_W-1:0] last_id_reg;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   wr_reg;
    logic [CW-1:0]   end_reg;
    logic [CW-1:0]   run_reg;
    logic            pvalid_reg;
    logic            fit_reg;
    logic            found_reg;
    logic            done_reg;

    ffba_pkg::req_t  req_reg;
    ffba_pkg::rsp_t  result_reg;
    logic [CW-1:0]   limit_reg;
    logic [AW-1:0]   pidx_reg;

    logic [CW-1:0]   n_eff;
    logic [ID_W-1:0] new_id;
    logic [CW-1:0]   run_inc;
    logic [CW-1:0]   pidx_inc;
    logic            rd_go;
    logic            owner_zero;
    logic            id_match;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [ID_W-1:0] ram_wdata;
    logic [ID_W-1:0] ram_rdata;

    ffba_ram #(
        .WIDTH(ID_W),
        .DEPTH(MEM_CELLS)
    ) u_cells (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign n_eff = (SW'(mem_size_reg) < SW'(MEM_CELLS)) ? CW'(mem_size_reg) : CW'(MEM_CELLS);
    assign new_id     = last_id_reg + ID_W'(1);
    assign run_inc    = run_reg + CW'(1);
    assign pidx_inc   = CW'(pidx_reg) + CW'(1);
    assign rd_go      = cmd.rd_en && (idx_reg != limit_reg);
    assign owner_zero = (ram_rdata == '0);
    assign id_match   = (CMP_W'(ram_rdata) == CMP_W'(req_reg.erase_id));

    always_comb
    begin
        stat.op        = req_reg.op;
        stat.exhausted = (last_id_reg == ID_W'(MAX_IDS - 1));
        stat.size_bad  = (req_reg.alloc_size == 8'd0)
                      || (SW'(req_reg.alloc_size) > SW'(limit_reg));
        stat.id_zero   = (req_reg.erase_id == 10'd0);
        stat.rd_done   = (idx_reg == limit_reg);
        stat.pvalid    = pvalid_reg;
        stat.fit       = fit_reg;
        stat.found     = found_reg;
        stat.fill_done = (wr_reg == end_reg);
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_reg[AW-1:0];
        ram_wdata = '0;
        if (cmd.erase_chk && pvalid_reg && id_match)
        begin
            ram_we    = 1'b1;
            ram_waddr = pidx_reg;
        end
        if (cmd.defrag_chk && pvalid_reg && !owner_zero)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
        end
        if (cmd.fill_id)
        begin
            ram_we    = 1'b1;
            ram_wdata = new_id;
        end
        if (cmd.fill_zero)
        begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg <= ffba_pkg::MEM_SIZE_RESET;
            last_id_reg  <= '0;
            idx_reg      <= '0;
            wr_reg       <= '0;
            end_reg      <= CW'(MEM_CELLS);
            run_reg      <= '0;
            pvalid_reg   <= 1'b0;
            fit_reg      <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cfg_we)
            begin
                mem_size_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                idx_reg    <= '0;
                wr_reg     <= '0;
                end_reg    <= n_eff;
                run_reg    <= '0;
                pvalid_reg <= 1'b0;
                fit_reg    <= 1'b0;
                found_reg  <= 1'b0;
            end
            else
            begin
                pvalid_reg <= rd_go;
                if (rd_go)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                if (cmd.alloc_chk && pvalid_reg)
                begin
                    if (!owner_zero)
                    begin
                        run_reg <= '0;
                    end
                    else
                    begin
                        run_reg <= run_inc;
                        if (SW'(run_inc) == SW'(req_reg.alloc_size))
                        begin
                            fit_reg <= 1'b1;
                            wr_reg  <= pidx_inc - CW'(req_reg.alloc_size);
                            end_reg <= pidx_inc;
                        end
                    end
                end
                if (cmd.erase_chk && pvalid_reg && id_match)
                begin
                    found_reg <= 1'b1;
                end
                if ((cmd.defrag_chk && pvalid_reg && !owner_zero)
                    || cmd.fill_id || cmd.fill_zero)
                begin
                    wr_reg <= wr_reg + CW'(1);
                end
                if (cmd.emit && (cmd.status == ffba_pkg::STAT_ALLOC_OK))
                begin
                    last_id_reg <= new_id;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req;
            limit_reg <= (req.op == ffba_pkg::OP_ERASE) ? CW'(MEM_CELLS) : n_eff;
        end
        if (rd_go)
        begin
            pidx_reg <= idx_reg[AW-1:0];
        end
        if (cmd.emit)
        begin
            result_reg.status   <= cmd.status;
            result_reg.block_id <= (cmd.status == ffba_pkg::STAT_ALLOC_OK) ? 10'(new_id)
                                                                          : 10'd0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fill_id || cmd.fill_zero) |-> (wr_reg < end_reg))
        else $error("fill pointer past end of run");

    a_no_back_to_back_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("two results in consecutive cycles");

    a_id_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.status == ffba_pkg::STAT_ALLOC_OK)
        |-> (last_id_reg != ID_W'(MAX_IDS - 1)))
        else $error("id allocated past the last id");

    a_defrag_compacts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.defrag_chk && pvalid_reg) |-> (wr_reg <= CW'(pidx_reg)))
        else $error("compaction write ahead of read");
`endif

endmodule

// ----- rtl/first_fit_block_allocator_top.sv -----
// Channel   Handshake          Payload
// command   start / busy       req (op, alloc_size, erase_id)
// result    done strobe        result (status, block_id)
// config    cfg_we             cfg_wdata (mem_size)
//
// An item is taken when start is high and busy low; done is high for one
// cycle with its result. With n = min(mem_size, MEM_CELLS), alloc scans up
// to n cells then fills alloc_size, erase scans all MEM_CELLS, defragment
// compacts and zeroes up to n; the single cell RAM port pair handles one
// cell per cycle. After reset a clearing pass zeroes every cell, busy high.
// The receiver cannot stall; done never repeats in back-to-back cycles.
module first_fit_block_allocator_top #(
    parameter int MEM_CELLS = 128,
    parameter int MAX_IDS   = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ffba_pkg::req_t req,
    output logic           done,
    output ffba_pkg::rsp_t result,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_wdata
);

    ffba_pkg::cmd_t  cmd;
    ffba_pkg::stat_t stat;

    ffba_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .cmd  (cmd),
        .busy (busy)
    );

    ffba_dp #(
        .MEM_CELLS(MEM_CELLS),
        .MAX_IDS  (MAX_IDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule
